>>> src/ssp_pkg.sv
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int unsigned MAX_PARTICLES = 65536;
  localparam int unsigned IDX_W         = 16;
  localparam int unsigned IDX_CMP_W     = 25;
  localparam logic [IDX_CMP_W-1:0] MAX_IDX = IDX_CMP_W'(MAX_PARTICLES);

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_REPULSION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_EN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIR_EN     = 3'd6;

  localparam logic [30:0] REPULSION_RESET = 31'd327680;

  typedef struct packed {
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [30:0] first_radius;
    logic [30:0] second_radius;
    logic        pair_active;
    logic        use_wrap;
  } ssp_in_t;

  typedef struct packed {
    logic [15:0]        out_first_index;
    logic [15:0]        out_second_index;
    logic               contact;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [47:0]        pair_potential;
    logic [47:0]        pair_virial;
  } ssp_out_t;

  typedef struct packed {
    logic [30:0] repulsion;
    logic [30:0] box_width;
    logic [30:0] box_height;
    logic        wrap_x;
    logic        wrap_y;
    logic        potential_enable;
    logic        virial_enable;
  } ssp_cfg_t;

  typedef struct packed {
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic        contact;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] s;
  } ssp_side_t;

  typedef struct packed {
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic        contact;
    logic        neg_x;
    logic        neg_y;
    logic        root_nz;
    logic [46:0] mag;
    logic [47:0] potential;
    logic [47:0] virial;
  } ssp_dside_t;

endpackage

>>> src/ssp_in_if.sv
`timescale 1ns / 1ps
interface ssp_in_if;
  import ssp_pkg::*;
  logic    valid;
  logic    ready;
  ssp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/ssp_out_if.sv
`timescale 1ns / 1ps
interface ssp_out_if;
  import ssp_pkg::*;
  logic     valid;
  logic     ready;
  ssp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/ssp_front.sv
`timescale 1ns / 1ps
module ssp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  ssp_pkg::ssp_in_t  in_data,
  input  ssp_pkg::ssp_cfg_t cfg,
  output logic              out_valid,
  output ssp_pkg::ssp_side_t out_side,
  output logic [63:0]       out_sum
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [15:0] i1;
    logic [15:0] i2;
    logic        act;
    logic        wx;
    logic        wy;
    logic [31:0] s;
  } fcom_t;

  logic [6:0] vld_r;

  fcom_t       c1_nxt, c1_r, c2_r, c3_r, c4_r;
  logic [32:0] dx1_nxt, dy1_nxt, dx1_r, dy1_r;
  logic [32:0] ax2_nxt, ay2_nxt, ax2_r, ay2_r;
  logic        px2_r, nx2_r, py2_r, ny2_r;
  logic [33:0] ex3_nxt, ey3_nxt, ex3_r, ey3_r;
  logic        fx3_nxt, fy3_nxt, fx3_r, fy3_r;
  logic [32:0] ax3_r, ay3_r;
  logic        px3_r, nx3_r, py3_r, ny3_r;
  logic [33:0] nex, ney;
  logic [32:0] mx4_nxt, my4_nxt, mx4_r, my4_r;
  logic        ngx4_nxt, ngy4_nxt, ngx4_r, ngy4_r;
  ssp_side_t   side5_nxt, side5_r, side6_r, side7_nxt, side7_r;
  logic [63:0] dx2_r, dy2_r, s2_r;
  logic [64:0] sum_nxt;
  logic [63:0] sum_r;

  always_comb begin
    c1_nxt.i1  = in_data.first_index;
    c1_nxt.i2  = in_data.second_index;
    c1_nxt.act = in_data.pair_active &&
                 ({9'd0, in_data.first_index} < MAX_IDX) &&
                 ({9'd0, in_data.second_index} < MAX_IDX);
    c1_nxt.wx  = in_data.use_wrap && cfg.wrap_x;
    c1_nxt.wy  = in_data.use_wrap && cfg.wrap_y;
    c1_nxt.s   = {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};
    dx1_nxt    = {in_data.first_x[31], in_data.first_x} -
                 {in_data.second_x[31], in_data.second_x};
    dy1_nxt    = {in_data.first_y[31], in_data.first_y} -
                 {in_data.second_y[31], in_data.second_y};
  end

  always_comb begin
    ax2_nxt = dx1_r[32] ? 33'(-dx1_r) : dx1_r;
    ay2_nxt = dy1_r[32] ? 33'(-dy1_r) : dy1_r;
  end

  always_comb begin
    ex3_nxt = {3'b000, cfg.box_width} - {1'b0, ax2_r};
    ey3_nxt = {3'b000, cfg.box_height} - {1'b0, ay2_r};
    fx3_nxt = c2_r.wx && ($signed(ex3_nxt) < $signed({1'b0, ax2_r}));
    fy3_nxt = c2_r.wy && ($signed(ey3_nxt) < $signed({1'b0, ay2_r}));
  end

  always_comb begin
    nex = -ex3_r;
    ney = -ey3_r;
    if (fx3_r) begin
      mx4_nxt  = ex3_r[33] ? nex[32:0] : ex3_r[32:0];
      ngx4_nxt = px3_r ? (!ex3_r[33] && (ex3_r != '0)) : ex3_r[33];
    end else begin
      mx4_nxt  = ax3_r;
      ngx4_nxt = nx3_r;
    end
    if (fy3_r) begin
      my4_nxt  = ey3_r[33] ? ney[32:0] : ey3_r[32:0];
      ngy4_nxt = py3_r ? (!ey3_r[33] && (ey3_r != '0)) : ey3_r[33];
    end else begin
      my4_nxt  = ay3_r;
      ngy4_nxt = ny3_r;
    end
  end

  always_comb begin
    side5_nxt.first_index  = c4_r.i1;
    side5_nxt.second_index = c4_r.i2;
    side5_nxt.contact      = c4_r.act && (mx4_r < {1'b0, c4_r.s}) &&
                             (my4_r < {1'b0, c4_r.s});
    side5_nxt.neg_x        = ngx4_r;
    side5_nxt.neg_y        = ngy4_r;
    side5_nxt.ax           = mx4_r[31:0];
    side5_nxt.ay           = my4_r[31:0];
    side5_nxt.s            = c4_r.s;
  end

  always_comb begin
    sum_nxt           = {1'b0, dx2_r} + {1'b0, dy2_r};
    side7_nxt         = side6_r;
    side7_nxt.contact = side6_r.contact && (sum_nxt < {1'b0, s2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= c1_nxt;
      dx1_r   <= dx1_nxt;
      dy1_r   <= dy1_nxt;
      c2_r    <= c1_r;
      ax2_r   <= ax2_nxt;
      ay2_r   <= ay2_nxt;
      px2_r   <= !dx1_r[32] && (dx1_r != '0);
      nx2_r   <= dx1_r[32];
      py2_r   <= !dy1_r[32] && (dy1_r != '0);
      ny2_r   <= dy1_r[32];
      c3_r    <= c2_r;
      ex3_r   <= ex3_nxt;
      ey3_r   <= ey3_nxt;
      fx3_r   <= fx3_nxt;
      fy3_r   <= fy3_nxt;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      px3_r   <= px2_r;
      nx3_r   <= nx2_r;
      py3_r   <= py2_r;
      ny3_r   <= ny2_r;
      c4_r    <= c3_r;
      mx4_r   <= mx4_nxt;
      my4_r   <= my4_nxt;
      ngx4_r  <= ngx4_nxt;
      ngy4_r  <= ngy4_nxt;
      side5_r <= side5_nxt;
      side6_r <= side5_r;
      dx2_r   <= 64'(side5_r.ax) * 64'(side5_r.ax);
      dy2_r   <= 64'(side5_r.ay) * 64'(side5_r.ay);
      s2_r    <= 64'(side5_r.s) * 64'(side5_r.s);
      side7_r <= side7_nxt;
      sum_r   <= sum_nxt[63:0];
    end
  end

  assign out_valid = vld_r[6];
  assign out_side  = side7_r;
  assign out_sum   = sum_r;

endmodule

>>> src/ssp_sqrt.sv
`timescale 1ns / 1ps
module ssp_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  ssp_pkg::ssp_side_t in_side,
  input  logic [63:0]        in_val,
  output logic               out_valid,
  output ssp_pkg::ssp_side_t out_side,
  output logic [31:0]        out_root
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] bits;
  } sq_lane_t;

  function automatic sq_lane_t sq_step(sq_lane_t l);
    logic [35:0] t;
    logic [35:0] trial;
    sq_lane_t    n;
    t      = {l.rem, l.bits[63:62]};
    trial  = {2'b00, l.root, 2'b01};
    n.bits = {l.bits[61:0], 2'b00};
    if (t >= trial) begin
      n.rem  = 34'(t - trial);
      n.root = {l.root[30:0], 1'b1};
    end else begin
      n.rem  = t[33:0];
      n.root = {l.root[30:0], 1'b0};
    end
    return n;
  endfunction

  logic [SQRT_STEPS-1:0] vld_r;
  sq_lane_t              lane_r [SQRT_STEPS];
  ssp_side_t             side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
    sq_lane_t  prev;
    ssp_side_t prev_side;
    if (k == 0) begin : g_first
      assign prev      = {34'd0, 32'd0, in_val};
      assign prev_side = in_side;
    end else begin : g_next
      assign prev      = lane_r[k-1];
      assign prev_side = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r[k] <= sq_step(prev);
        side_r[k] <= prev_side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];
  assign out_root  = lane_r[SQRT_STEPS-1].root;

endmodule

>>> src/ssp_div.sv
`timescale 1ns / 1ps
module ssp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  ssp_pkg::ssp_dside_t in_side,
  input  logic [31:0]         in_ax,
  input  logic [31:0]         in_ay,
  input  logic [31:0]         in_root,
  output logic                out_valid,
  output ssp_pkg::ssp_dside_t out_side,
  output logic [30:0]         out_nx,
  output logic [30:0]         out_ny
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] bits;
    logic [30:0] quo;
  } dv_lane_t;

  function automatic dv_lane_t dv_step(dv_lane_t l, logic [31:0] d);
    logic [32:0] t;
    dv_lane_t    n;
    t      = {l.rem, l.bits[30]};
    n.bits = {l.bits[29:0], 1'b0};
    if (t >= {1'b0, d}) begin
      n.rem = 32'(t - {1'b0, d});
      n.quo = {l.quo[29:0], 1'b1};
    end else begin
      n.rem = t[31:0];
      n.quo = {l.quo[29:0], 1'b0};
    end
    return n;
  endfunction

  logic [DIV_STEPS-1:0] vld_r;
  dv_lane_t             lx_r   [DIV_STEPS];
  dv_lane_t             ly_r   [DIV_STEPS];
  logic [31:0]          root_r [DIV_STEPS];
  ssp_dside_t           side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    dv_lane_t    px, py;
    logic [31:0] proot;
    ssp_dside_t  pside;
    if (k == 0) begin : g_first
      assign px    = {1'b0, in_ax[31:1], in_ax[0], 30'd0, 31'd0};
      assign py    = {1'b0, in_ay[31:1], in_ay[0], 30'd0, 31'd0};
      assign proot = in_root;
      assign pside = in_side;
    end else begin : g_next
      assign px    = lx_r[k-1];
      assign py    = ly_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lx_r[k]   <= dv_step(px, proot);
        ly_r[k]   <= dv_step(py, proot);
        root_r[k] <= proot;
        side_r[k] <= pside;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];
  assign out_nx    = lx_r[DIV_STEPS-1].quo;
  assign out_ny    = ly_r[DIV_STEPS-1].quo;

endmodule

>>> src/ssp_back.sv
`timescale 1ns / 1ps
module ssp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  ssp_pkg::ssp_side_t in_side,
  input  logic [31:0]        in_root,
  input  ssp_pkg::ssp_cfg_t  cfg,
  output logic               out_valid,
  output ssp_pkg::ssp_out_t  out_data
);
  import ssp_pkg::*;

  function automatic logic [31:0] sat_force(logic [47:0] v, logic neg);
    logic [47:0] nv;
    nv = 48'd0 - v;
    if (neg) begin
      return (v > 48'h0000_8000_0000) ? 32'h8000_0000 : nv[31:0];
    end
    return (v > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
  endfunction

  logic [3:0]  vld_r;
  ssp_side_t   side1_r, side2_r, side3_r, side4_r;
  logic [31:0] root1_r, root2_r, root3_r, root4_r;
  logic [31:0] ov1_r;
  logic [62:0] magp2_r;
  logic [63:0] ov2_r;
  logic [46:0] mag3_r;
  logic [62:0] pl3_r, ph3_r;
  logic [63:0] vl3_r;
  logic [46:0] vh3_r;
  logic [94:0] pot_sum;
  logic [61:0] pot_q;
  logic [78:0] vir_sum;
  logic [62:0] vir_q;
  ssp_dside_t  ds4_nxt, ds4_r;

  logic        dv_valid;
  ssp_dside_t  dv_side;
  logic [30:0] dv_nx, dv_ny;

  logic        v5_r, v6_r;
  ssp_dside_t  ds5_r;
  logic [62:0] fxl5_r, fyl5_r;
  logic [45:0] fxh5_r, fyh5_r;
  logic [77:0] fx_sum, fy_sum;
  ssp_out_t    out_nxt, out_r;

  always_comb begin
    pot_sum = {ph3_r, 32'd0} + 95'(pl3_r);
    pot_q   = pot_sum[94:33];
    vir_sum = {vh3_r, 32'd0} + 79'(vl3_r);
    vir_q   = vir_sum[78:16];
    ds4_nxt.first_index  = side3_r.first_index;
    ds4_nxt.second_index = side3_r.second_index;
    ds4_nxt.contact      = side3_r.contact;
    ds4_nxt.neg_x        = side3_r.neg_x;
    ds4_nxt.neg_y        = side3_r.neg_y;
    ds4_nxt.root_nz      = (root3_r != '0);
    ds4_nxt.mag          = mag3_r;
    if (side3_r.contact && cfg.potential_enable) begin
      ds4_nxt.potential = (pot_q[61:48] != '0) ? '1 : pot_q[47:0];
    end else begin
      ds4_nxt.potential = '0;
    end
    if (side3_r.contact && cfg.virial_enable) begin
      ds4_nxt.virial = (vir_q[62:48] != '0) ? '1 : vir_q[47:0];
    end else begin
      ds4_nxt.virial = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= in_side;
      root1_r <= in_root;
      ov1_r   <= in_side.s - in_root;
      side2_r <= side1_r;
      root2_r <= root1_r;
      magp2_r <= 63'(cfg.repulsion) * 63'(ov1_r);
      ov2_r   <= 64'(ov1_r) * 64'(ov1_r);
      side3_r <= side2_r;
      root3_r <= root2_r;
      mag3_r  <= magp2_r[62:16];
      pl3_r   <= 63'(cfg.repulsion) * 63'(ov2_r[31:0]);
      ph3_r   <= 63'(cfg.repulsion) * 63'(ov2_r[63:32]);
      vl3_r   <= 64'(magp2_r[47:16]) * 64'(root2_r);
      vh3_r   <= 47'(magp2_r[62:48]) * 47'(root2_r);
      side4_r <= side3_r;
      root4_r <= root3_r;
      ds4_r   <= ds4_nxt;
    end
  end

  ssp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vld_r[3]),
    .in_side   (ds4_r),
    .in_ax     (side4_r.ax),
    .in_ay     (side4_r.ay),
    .in_root   (root4_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_nx    (dv_nx),
    .out_ny    (dv_ny)
  );

  always_comb begin
    fx_sum = {fxh5_r, 32'd0} + 78'(fxl5_r);
    fy_sum = {fyh5_r, 32'd0} + 78'(fyl5_r);
    out_nxt.out_first_index  = ds5_r.first_index;
    out_nxt.out_second_index = ds5_r.second_index;
    out_nxt.contact          = ds5_r.contact;
    if (ds5_r.contact && ds5_r.root_nz) begin
      out_nxt.force_x = sat_force(fx_sum[77:30], ds5_r.neg_x);
      out_nxt.force_y = sat_force(fy_sum[77:30], ds5_r.neg_y);
    end else begin
      out_nxt.force_x = '0;
      out_nxt.force_y = '0;
    end
    out_nxt.pair_potential = ds5_r.potential;
    out_nxt.pair_virial    = ds5_r.virial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= dv_valid;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds5_r  <= dv_side;
      fxl5_r <= 63'(dv_side.mag[31:0]) * 63'(dv_nx);
      fxh5_r <= 46'(dv_side.mag[46:32]) * 46'(dv_nx);
      fyl5_r <= 63'(dv_side.mag[31:0]) * 63'(dv_ny);
      fyh5_r <= 46'(dv_side.mag[46:32]) * 46'(dv_ny);
      out_r  <= out_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = out_r;

endmodule

>>> src/soft_sphere_pair_force_2d.sv
`timescale 1ns / 1ps
// Channel   Dir   Handshake        Payload
// in_pair   in    valid / ready    one neighbor pair (ssp_in_t)
// out_res   out   valid / ready    one force item (ssp_out_t)
// cfg_*     in    cfg_we           cfg_index, cfg_data
//
// One item per cycle unless out_res stalls; 7 front stages (difference,
// minimum image, squares), 32 square-root stages, 4 spring/energy stages,
// 31 normal-divider stages, 2 force stages ending in the output register.
// Synchronous active-low reset clears valid bits and resets config registers.
// A held output freezes every stage at once; no item is dropped or repeated.
module soft_sphere_pair_force_2d (
  input  logic                           clk,
  input  logic                           rst_n,
  ssp_in_if.sink                         in_pair,
  ssp_out_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssp_pkg::*;

  ssp_cfg_t  cfg_r;
  logic      adv;
  logic      fr_valid, sq_valid, bk_valid;
  ssp_side_t fr_side, sq_side;
  logic [63:0] fr_sum;
  logic [31:0] sq_root;
  ssp_out_t  bk_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repulsion        <= REPULSION_RESET;
      cfg_r.box_width        <= '0;
      cfg_r.box_height       <= '0;
      cfg_r.wrap_x           <= 1'b0;
      cfg_r.wrap_y           <= 1'b0;
      cfg_r.potential_enable <= 1'b0;
      cfg_r.virial_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPULSION:  cfg_r.repulsion        <= cfg_data;
        CFG_BOX_WIDTH:  cfg_r.box_width        <= cfg_data;
        CFG_BOX_HEIGHT: cfg_r.box_height       <= cfg_data;
        CFG_WRAP_X:     cfg_r.wrap_x           <= cfg_data[0];
        CFG_WRAP_Y:     cfg_r.wrap_y           <= cfg_data[0];
        CFG_POT_EN:     cfg_r.potential_enable <= cfg_data[0];
        CFG_VIR_EN:     cfg_r.virial_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv           = !bk_valid || out_res.ready;
  assign in_pair.ready = adv;

  ssp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_pair.valid),
    .in_data   (in_pair.data),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_sum   (fr_sum)
  );

  ssp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_val    (fr_sum),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  ssp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_root   (sq_root),
    .cfg       (cfg_r),
    .out_valid (bk_valid),
    .out_data  (bk_data)
  );

  assign out_res.valid = bk_valid;
  assign out_res.data  = bk_data;

  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    bk_valid && !bk_data.contact |-> bk_data.force_x == '0 &&
      bk_data.force_y == '0 && bk_data.pair_potential == '0 &&
      bk_data.pair_virial == '0)
    else $error("force or energy on a pair without contact");

  a_pot_off: assert property (@(posedge clk) disable iff (!rst_n)
    bk_valid && !cfg_r.potential_enable |-> bk_data.pair_potential == '0)
    else $error("potential given while disabled");

  a_vir_off: assert property (@(posedge clk) disable iff (!rst_n)
    bk_valid && !cfg_r.virial_enable |-> bk_data.pair_virial == '0)
    else $error("virial given while disabled");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_valid) && $stable(fr_valid))
    else $error("pipeline moved during stall");

endmodule

>>> dv/soft_sphere_pair_force_checker.sv
`timescale 1ns / 1ps
module soft_sphere_pair_force_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  ssp_in_if                              in_ch,
  ssp_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import ssp_pkg::*;

  ssp_cfg_t cfg;
  ssp_out_t force_q[$];

  function automatic bit [63:0] int_sqrt(input bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] scaled_product(input bit [63:0] a, input bit [63:0] b,
                                               input int sh);
    bit [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic longint min_image(input longint d, input longint box);
    longint a;
    longint e;
    a = d < 0 ? -d : d;
    e = box - a;
    if (e < a) d = d > 0 ? -e : e;
    return d;
  endfunction

  function automatic bit [31:0] force_component(input bit [63:0] mag, input bit [63:0] n,
                                                input bit neg);
    bit [63:0] v;
    v = scaled_product(mag, n, 30);
    if (neg) begin
      if (v > 64'h8000_0000) v = 64'h8000_0000;
      return 32'(0 - v);
    end
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    return v[31:0];
  endfunction

  function automatic ssp_out_t force_of_pair(input ssp_in_t p, input ssp_cfg_t c);
    ssp_out_t o;
    longint dx;
    longint dy;
    bit [63:0] ax, ay, s, s2, dx2, dy2, r, ov, mag, t;
    o = '0;
    o.out_first_index = p.first_index;
    o.out_second_index = p.second_index;
    if (!p.pair_active) return o;
    dx = longint'($signed(p.first_x)) - longint'($signed(p.second_x));
    dy = longint'($signed(p.first_y)) - longint'($signed(p.second_y));
    if (p.use_wrap && c.wrap_x) dx = min_image(dx, longint'(c.box_width));
    if (p.use_wrap && c.wrap_y) dy = min_image(dy, longint'(c.box_height));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = 64'(p.first_radius) + 64'(p.second_radius);
    if (ax >= s || ay >= s) return o;
    s2 = s * s;
    dx2 = ax * ax;
    dy2 = ay * ay;
    if (dy2 >= s2 - dx2) return o;
    o.contact = 1'b1;
    r = int_sqrt(dx2 + dy2);
    ov = s - r;
    mag = (64'(c.repulsion) * ov) >> 16;
    if (r != 0) begin
      o.force_x = force_component(mag, (ax << 30) / r, dx < 0);
      o.force_y = force_component(mag, (ay << 30) / r, dy < 0);
    end
    if (c.potential_enable) begin
      t = scaled_product(64'(c.repulsion), ov * ov, 33);
      o.pair_potential = t > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : t[47:0];
    end
    if (c.virial_enable) begin
      t = scaled_product(mag, r, 16);
      o.pair_virial = t > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : t[47:0];
    end
    return o;
  endfunction

  function automatic void check_field(input string name, input bit [63:0] exp_v,
                                      input bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  assign pending = force_q.size();

  always @(posedge clk) begin
    ssp_out_t e;
    ssp_out_t a;
    if (!rst_n) begin
      cfg <= '{repulsion: REPULSION_RESET, default: '0};
      errors = 0;
      force_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) force_q.push_back(force_of_pair(in_ch.data, cfg));
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (force_q.size() == 0) begin
          $display("%0t: unexpected item expected none actual %0h", $time, a);
          errors++;
        end else begin
          e = force_q.pop_front();
          check_field("first_index", 64'(e.out_first_index), 64'(a.out_first_index));
          check_field("second_index", 64'(e.out_second_index), 64'(a.out_second_index));
          check_field("contact", 64'(e.contact), 64'(a.contact));
          check_field("force_x", 64'(e.force_x), 64'(a.force_x));
          check_field("force_y", 64'(e.force_y), 64'(a.force_y));
          check_field("pair_potential", 64'(e.pair_potential), 64'(a.pair_potential));
          check_field("pair_virial", 64'(e.pair_virial), 64'(a.pair_virial));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPULSION:  cfg.repulsion <= cfg_data;
          CFG_BOX_WIDTH:  cfg.box_width <= cfg_data;
          CFG_BOX_HEIGHT: cfg.box_height <= cfg_data;
          CFG_WRAP_X:     cfg.wrap_x <= cfg_data[0];
          CFG_WRAP_Y:     cfg.wrap_y <= cfg_data[0];
          CFG_POT_EN:     cfg.potential_enable <= cfg_data[0];
          CFG_VIR_EN:     cfg.virial_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> dv/soft_sphere_pair_force_2d_tb.sv
`timescale 1ns / 1ps
module soft_sphere_pair_force_2d_tb;
  import ssp_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  bit                    send_idle;
  bit                    recv_stall;
  int                    idle_pct;
  logic [30:0]           box_w;
  logic [30:0]           box_h;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();

  soft_sphere_pair_force_2d DUT (
    .clk(clk), .rst_n(rst_n), .in_pair(in_ch), .out_res(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  soft_sphere_pair_force_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_stall && $urandom_range(0, 99) < idle_pct);
  end

  task automatic send_pair(input ssp_in_t it);
    while (send_idle && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (90) @(posedge clk);
  endtask

  task automatic set_regs(input logic [30:0] rep, input logic [30:0] bw, input logic [30:0] bh,
                          input bit wx, input bit wy, input bit pe, input bit ve);
    logic [30:0] vals [7];
    vals = '{rep, bw, bh, 31'(wx), 31'(wy), 31'(pe), 31'(ve)};
    box_w = bw;
    box_h = bh;
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic ssp_in_t make_pair(input logic [31:0] x1, input logic [31:0] y1,
                                        input logic [31:0] x2, input logic [31:0] y2,
                                        input logic [30:0] r1, input logic [30:0] r2,
                                        input bit act, input bit wr);
    ssp_in_t p;
    p.first_index = 16'($urandom);
    p.second_index = 16'($urandom);
    p.first_x = x1;
    p.first_y = y1;
    p.second_x = x2;
    p.second_y = y2;
    p.first_radius = r1;
    p.second_radius = r2;
    p.pair_active = act;
    p.use_wrap = wr;
    return p;
  endfunction

  function automatic logic [31:0] near(input logic [31:0] c, input int span);
    return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic ssp_in_t random_pair;
    ssp_in_t p;
    int kind;
    logic [31:0] x1, y1;
    kind = $urandom_range(0, 9);
    x1 = 32'($signed(21'($urandom)) <<< 4);
    y1 = 32'($signed(21'($urandom)) <<< 4);
    p = make_pair(x1, y1, near(x1, 1 << 21), near(y1, 1 << 21),
                  31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)),
                  $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
    if (kind == 0) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p.pair_active = 1'b1;
      p.first_radius[30] = 1'($urandom_range(0, 1));
    end else if (kind >= 8) begin
      p.first_x = near(32'd0, 1 << 20);
      p.second_x = near(32'(box_w), 1 << 20);
      p.first_y = near(32'(box_h), 1 << 20);
      p.second_y = near(32'd0, 1 << 20);
      p.use_wrap = 1'b1;
    end
    return p;
  endfunction

  initial begin
    ssp_in_t p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle = 0;
    recv_stall = 0;
    idle_pct = 0;
    box_w = '0;
    box_h = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first
    send_pair(make_pair(32'h0001_0000, 0, 0, 0, 31'h0001_0000, 31'h0001_0000, 1'b1, 1'b0));
    drain();
    set_regs(31'h7FFF_FFFF, 31'h0010_0000, 31'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    send_pair(make_pair(0, 0, 0, 0, 31'h0002_0000, 31'h0001_0000, 1'b1, 1'b0));
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 1'b1, 1'b0));
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1));
    send_pair(make_pair(32'h0003_0000, 0, 0, 0, 31'h0001_0000, 31'h0002_0000, 1'b1, 1'b0));
    send_pair(make_pair(0, 32'h0003_0000, 0, 0, 31'h0001_0000, 31'h0002_0000, 1'b1, 1'b0));
    send_pair(make_pair(32'h0001_0000, 32'h0001_0000, 0, 0, 31'h0004_0000, 31'h0004_0000,
                        1'b0, 1'b0));
    send_pair(make_pair(32'h0000_1000, 0, 32'h000F_F000, 0, 31'h0001_0000, 31'h0001_0000,
                        1'b1, 1'b1));
    send_pair(make_pair(32'h0000_1000, 0, 32'h000F_F000, 0, 31'h0001_0000, 31'h0001_0000,
                        1'b1, 1'b0));
    send_pair(make_pair(0, 0, 32'h0030_0000, 32'h0050_0000, 31'h7FFF_FFFF, 31'h0, 1'b1, 1'b1));
    send_pair(make_pair(32'hFFFF_FFFF, 0, 32'h0000_0001, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        1'b1, 1'b0));
    p = make_pair('1, '1, 0, 0, '1, '1, 1'b1, 1'b1);
    p.first_index = '1;
    p.second_index = '1;
    send_pair(p);
    p.first_index = '0;
    p.second_index = '0;
    send_pair(p);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(31'd327680, 31'h0100_0000, 31'h0080_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        1: set_regs(31'h0, 31'h0, 31'h0, 1'b1, 1'b0, 1'b1, 1'b1);
        2: set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0040_0000, 1'b0, 1'b1, 1'b1, 1'b0);
        3: set_regs(31'($urandom), 31'($urandom_range(0, 1 << 26)),
                    31'($urandom_range(0, 1 << 26)), 1'b1, 1'b1, 1'b0, 1'b1);
        default: set_regs(31'($urandom_range(0, 1 << 24)), 31'($urandom_range(1 << 20, 1 << 26)),
                          31'($urandom_range(1 << 20, 1 << 26)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
      endcase
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; idle_pct = 0;  end
        1: begin send_idle = 1; recv_stall = 0; idle_pct = 53; end
        2: begin send_idle = 0; recv_stall = 1; idle_pct = 53; end
        default: begin send_idle = 1; recv_stall = 1; idle_pct = 12; end
      endcase
      for (int i = 0; i < 100; i++) begin
        send_pair(random_pair());
        if (i == 50) begin
          in_ch.valid <= 1'b0;
          do @(negedge clk); while (pending != 0);
          @(posedge clk);
        end
      end
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
